// ===== hdl/fbe_pkg.sv =====
// Shared constants, types and tables for the Fourier basis evaluator.
// No dependencies; used by fbe_cordic and fourier_basis_evaluator.
`timescale 1ns / 1ps
`default_nettype none

package fbe_pkg;

  // Default parameter values
  localparam int DEF_ROTATION_STAGES = 20;
  localparam int DEF_HARMONIC_BITS   = 8;

  // Fixed field widths
  localparam int ANGLE_W  = 32;
  localparam int VALUE_W  = 18;
  localparam int FIRST_W  = 26;
  localparam int SECOND_W = 34;
  localparam int CORDIC_W = 32;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_USE_COSINE = 2'd0,
    REG_HARMONIC   = 2'd1
  } cfg_reg_t;

  // round(2^40 / (2*pi)) split at bit 32: HI * 2^32 + LO
  localparam logic [31:0] PHASE_SCALE_LO = 32'd3194018708;
  localparam logic [5:0]  PHASE_SCALE_HI = 6'd40;

  // round(2^30 / K), CORDIC gain removed up front
  localparam logic signed [CORDIC_W-1:0] CORDIC_INV_GAIN = 32'sd652032874;

  // sqrt(2) with 30 fraction bits
  localparam logic [30:0] SQRT2_Q30 = 31'd1518500250;

  // atan(2^-i) in turns, 32 fraction bits
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  // Quarter turn the residual phase sits in
  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  // Control that travels alongside the CORDIC data
  typedef struct packed {
    logic  valid;
    quad_t quad;
  } cordic_tag_t;

endpackage

`default_nettype wire

// ===== hdl/fbe_cordic.sv =====
// Pipelined rotation-mode CORDIC, one micro-rotation per register stage.
// Depends on fbe_pkg (arctangent table, gain constant, tag struct).
`timescale 1ns / 1ps
`default_nettype none

module fbe_cordic #(
  parameter int STAGES = fbe_pkg::DEF_ROTATION_STAGES
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire fbe_pkg::cordic_tag_t                  in_tag,
  input  wire logic signed [fbe_pkg::CORDIC_W-1:0]   z_in,
  output fbe_pkg::cordic_tag_t                       out_tag,
  output logic signed [fbe_pkg::CORDIC_W-1:0]        cos_out,
  output logic signed [fbe_pkg::CORDIC_W-1:0]        sin_out
);

  localparam int W = fbe_pkg::CORDIC_W;

  logic signed [W-1:0] xr [STAGES];
  logic signed [W-1:0] yr [STAGES];
  logic signed [W-1:0] zr [STAGES];
  logic                vr [STAGES];
  fbe_pkg::quad_t      qr [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [W-1:0] x_cur, y_cur, z_cur, x_sh, y_sh, angle_step;
    logic                v_cur;
    fbe_pkg::quad_t      q_cur;

    if (i == 0) begin : g_first
      assign x_cur = fbe_pkg::CORDIC_INV_GAIN;
      assign y_cur = '0;
      assign z_cur = z_in;
      assign v_cur = in_tag.valid;
      assign q_cur = in_tag.quad;
    end else begin : g_rest
      assign x_cur = xr[i-1];
      assign y_cur = yr[i-1];
      assign z_cur = zr[i-1];
      assign v_cur = vr[i-1];
      assign q_cur = qr[i-1];
    end

    assign x_sh       = x_cur >>> i;
    assign y_sh       = y_cur >>> i;
    assign angle_step = $signed(fbe_pkg::ATAN_TURNS[i]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vr[i] <= 1'b0;
      end else begin
        vr[i] <= v_cur;
      end
      qr[i] <= q_cur;
      // rotate toward zero residual angle
      if (!z_cur[W-1]) begin
        xr[i] <= x_cur - y_sh;
        yr[i] <= y_cur + x_sh;
        zr[i] <= z_cur - angle_step;
      end else begin
        xr[i] <= x_cur + y_sh;
        yr[i] <= y_cur - x_sh;
        zr[i] <= z_cur + angle_step;
      end
    end
  end

  assign out_tag.valid = vr[STAGES-1];
  assign out_tag.quad  = qr[STAGES-1];
  assign cos_out       = xr[STAGES-1];
  assign sin_out       = yr[STAGES-1];

endmodule

`default_nettype wire

// ===== hdl/fourier_basis_evaluator.sv =====
// Top level of the normalized Fourier basis evaluator.
// Depends on fbe_pkg and instantiates fbe_cordic.
`timescale 1ns / 1ps
`default_nettype none

// Evaluates sqrt(2)*cos(kx) or sqrt(2)*sin(kx) together with its first and
// second derivative for one angle x (Q7.24 radians) per item. The harmonic k
// and the cosine/sine select are configuration registers; the user must write
// them only while no item is in flight, as the block itself does not enforce
// this. The block is a fully pipelined datapath: it takes a new item on every
// clock (busy is low except during reset) and returns each result flagged by a
// one-cycle done pulse. The depth is set by the CORDIC, one micro-rotation per
// stage, plus five stages of phase reduction and five of scaling. The receiver
// cannot stall, so results must be captured in the done cycle.
// For k = 0 the value is 1.0 (cosine) or 0 (sine) and both derivatives are 0.
module fourier_basis_evaluator #(
  parameter int ROTATION_STAGES = fbe_pkg::DEF_ROTATION_STAGES,
  parameter int HARMONIC_BITS   = fbe_pkg::DEF_HARMONIC_BITS
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // item handshake
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic signed [fbe_pkg::ANGLE_W-1:0]     angle,
  // results
  output logic                                        done,
  output logic signed [fbe_pkg::VALUE_W-1:0]          value,
  output logic signed [fbe_pkg::FIRST_W-1:0]          first_derivative,
  output logic signed [fbe_pkg::SECOND_W-1:0]         second_derivative,
  // configuration writes
  input  wire logic                                   cfg_we,
  input  wire logic [fbe_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  wire logic [HARMONIC_BITS-1:0]               cfg_wdata
);

  localparam int HB     = HARMONIC_BITS;
  localparam int CW     = fbe_pkg::CORDIC_W;
  localparam int MLO_W  = 32 + HB;       // low phase word times k
  localparam int D24_W  = 28;            // 24-fraction-bit terms
  localparam int P1_W   = HB + 1 + D24_W;
  localparam int P2_W   = 2 * HB + 1 + D24_W;

  // ---------------------------------------------------------------------
  // Configuration registers. k*k is formed at write time so the scaling
  // path needs only one multiply per term.
  // ---------------------------------------------------------------------
  logic                use_cosine;
  logic [HB-1:0]       harmonic;
  logic [2*HB-1:0]     harmonic_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_cosine  <= 1'b1;
      harmonic    <= '0;
      harmonic_sq <= '0;
    end else if (cfg_we) begin
      unique case (fbe_pkg::cfg_reg_t'(cfg_index))
        fbe_pkg::REG_USE_COSINE: use_cosine <= cfg_wdata[0];
        fbe_pkg::REG_HARMONIC: begin
          harmonic    <= cfg_wdata;
          harmonic_sq <= (2*HB)'(cfg_wdata) * (2*HB)'(cfg_wdata);
        end
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // Fully pipelined: nothing holds an item off
  assign busy = rst;

  logic accept;
  assign accept = start && !busy;

  // ---------------------------------------------------------------------
  // Phase reduction: turns = angle * 2^40/(2*pi) * k, mod one turn.
  // The 64-bit product is built from 32-bit partial products.
  // ---------------------------------------------------------------------
  // S1: angle times the two halves of the phase scale
  logic               s1_valid;
  logic [63:0]        s1_p_lo;
  logic [31:0]        s1_p_hi;
  logic signed [64:0] p_lo_full;

  assign p_lo_full = angle * $signed({1'b0, fbe_pkg::PHASE_SCALE_LO});

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_p_lo <= p_lo_full[63:0];
    s1_p_hi <= unsigned'(angle) * 32'(fbe_pkg::PHASE_SCALE_HI);
  end

  // S2: combine into turns with 64 fraction bits
  logic        s2_valid;
  logic [63:0] s2_turns;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_turns <= s1_p_lo + {s1_p_hi, 32'd0};
  end

  // S3: times k, split in halves; only bits 63:32 of the product matter
  logic             s3_valid;
  logic [MLO_W-1:0] s3_m_lo;
  logic [31:0]      s3_m_hi;
  logic [MLO_W-1:0] m_hi_full;

  assign m_hi_full = MLO_W'(s2_turns[63:32]) * MLO_W'(harmonic);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_m_lo <= MLO_W'(s2_turns[31:0]) * MLO_W'(harmonic);
    s3_m_hi <= m_hi_full[31:0];
  end

  // S4: phase in turns, 32 fraction bits
  logic        s4_valid;
  logic [31:0] s4_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_phase <= s3_m_hi + 32'(s3_m_lo[MLO_W-1:32]);
  end

  // S5: nearest quarter turn and residual within +-1/8 turn
  fbe_pkg::cordic_tag_t s5_tag;
  logic signed [CW-1:0] s5_resid;
  logic [31:0]          phase_rnd;
  logic [1:0]           quad_now;

  assign phase_rnd = s4_phase + 32'h2000_0000;
  assign quad_now  = phase_rnd[31:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_tag.valid <= 1'b0;
    end else begin
      s5_tag.valid <= s4_valid;
    end
    s5_tag.quad <= fbe_pkg::quad_t'(quad_now);
    s5_resid    <= $signed(s4_phase - {quad_now, 30'd0});
  end

  // ---------------------------------------------------------------------
  // CORDIC: cos/sin of the residual, 30 fraction bits
  // ---------------------------------------------------------------------
  fbe_pkg::cordic_tag_t cd_tag;
  logic signed [CW-1:0] cd_cos, cd_sin;

  fbe_cordic #(
    .STAGES (ROTATION_STAGES)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .in_tag  (s5_tag),
    .z_in    (s5_resid),
    .out_tag (cd_tag),
    .cos_out (cd_cos),
    .sin_out (cd_sin)
  );

  // ---------------------------------------------------------------------
  // Scaling
  // ---------------------------------------------------------------------
  // A: undo the quadrant fold, pick basis and derivative terms
  logic                 a_valid;
  logic signed [CW-1:0] a_basis, a_deriv;
  logic signed [CW-1:0] qc, qs;

  always_comb begin
    unique case (cd_tag.quad)
      fbe_pkg::QUAD_0: begin qc = cd_cos;  qs = cd_sin;  end
      fbe_pkg::QUAD_1: begin qc = -cd_sin; qs = cd_cos;  end
      fbe_pkg::QUAD_2: begin qc = -cd_cos; qs = -cd_sin; end
      default:         begin qc = cd_sin;  qs = -cd_cos; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= cd_tag.valid;
    end
    if (use_cosine) begin
      a_basis <= qc;
      a_deriv <= -qs;
    end else begin
      a_basis <= qs;
      a_deriv <= qc;
    end
  end

  // B: times sqrt(2)
  logic               b_valid;
  logic signed [63:0] b_mb, b_md;
  logic signed [31:0] sqrt2_s;

  assign sqrt2_s = $signed({1'b0, fbe_pkg::SQRT2_Q30});

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_mb <= a_basis * sqrt2_s;
    b_md <= a_deriv * sqrt2_s;
  end

  // C: round half up to 24 fraction bits
  logic                    c_valid;
  logic signed [D24_W-1:0] c_b24, c_d24;
  logic signed [63:0]      mb_rnd, md_rnd;

  assign mb_rnd = b_mb + 64'sh8_0000_0000;
  assign md_rnd = b_md + 64'sh8_0000_0000;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
    c_b24 <= mb_rnd[63:36];
    c_d24 <= md_rnd[63:36];
  end

  // D: derivative terms times k and k*k
  logic                    d_valid;
  logic signed [D24_W-1:0] d_b24;
  logic signed [P1_W-1:0]  d_p1;
  logic signed [P2_W-1:0]  d_p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= c_valid;
    end
    d_b24 <= c_b24;
    d_p1  <= $signed({1'b0, harmonic}) * c_d24;
    d_p2  <= $signed({1'b0, harmonic_sq}) * c_b24;
  end

  // E: final rounding to 16 fraction bits, zero-harmonic override
  logic signed [63:0] e0, e1, e2;

  assign e0 = (64'(d_b24) + 64'sd128) >>> 8;
  assign e1 = (64'(d_p1) + 64'sd128) >>> 8;
  assign e2 = (64'sd128 - 64'(d_p2)) >>> 8;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_valid;
    end
    if (harmonic == '0) begin
      // constant basis: 1.0 for cosine, 0 for sine
      value             <= use_cosine ? fbe_pkg::VALUE_W'(65536) : '0;
      first_derivative  <= '0;
      second_derivative <= '0;
    end else begin
      value             <= e0[fbe_pkg::VALUE_W-1:0];
      first_derivative  <= e1[fbe_pkg::FIRST_W-1:0];
      second_derivative <= e2[fbe_pkg::SECOND_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_fourier_basis_evaluator.sv =====
// Self-checking testbench for fourier_basis_evaluator: directed and random angles under
// changing harmonic/select settings, checked against an in-bench bit-exact predictor.
// Depends on fbe_pkg and the RTL top level; no files, no arguments.
`timescale 1ns / 1ps

module tb_fourier_basis_evaluator;

  localparam int LATENCY     = fbe_pkg::DEF_ROTATION_STAGES + 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1125;

  // Register indexes the block does not decode; writes there must be ignored.
  localparam logic [fbe_pkg::CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [fbe_pkg::CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

  // Gap patterns between items
  localparam int GAP_NONE = 0;  // back to back
  localparam int GAP_WIDE = 1;  // random gap, possibly none, after every item
  localparam int GAP_RARE = 2;  // mostly back to back, now and then a gap

  // Predictor constants
  localparam int          CORDIC_STEPS  = 20;
  localparam logic [63:0] TURNS_PER_RAD = 64'd174992710548;  // round(2^40 / 2pi)
  localparam longint      START_X       = 652032874;         // round(2^30 / K)
  localparam longint      ROOT2_Q30     = 1518500250;
  localparam longint      ATAN_STEP [CORDIC_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304
  };

  // Handy angles, Q7.24 radians
  localparam logic [31:0] QUARTER_PI = 32'd13176795;
  localparam logic [31:0] HALF_PI    = 32'd26353589;
  localparam logic [31:0] FULL_PI    = 32'd52707179;
  localparam logic [31:0] ANGLE_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] ANGLE_MIN  = 32'h8000_0000;

  typedef struct packed {
    logic signed [fbe_pkg::VALUE_W-1:0]  value;
    logic signed [fbe_pkg::FIRST_W-1:0]  first;
    logic signed [fbe_pkg::SECOND_W-1:0] second;
  } basis_t;

  // DUT signals
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [fbe_pkg::ANGLE_W-1:0] angle = '0;
  logic done;
  logic signed [fbe_pkg::VALUE_W-1:0]  value;
  logic signed [fbe_pkg::FIRST_W-1:0]  first_derivative;
  logic signed [fbe_pkg::SECOND_W-1:0] second_derivative;
  logic cfg_we = 1'b0;
  logic [fbe_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [fbe_pkg::DEF_HARMONIC_BITS-1:0] cfg_wdata = '0;

  // Bench state
  logic [31:0] angles_waiting [$];  // items not yet driven
  basis_t      basis_due [$];       // predictions awaiting their result
  basis_t      want;
  logic        took = 1'b0;         // item accepted at the last rising edge
  int          gap_left = 0;
  int          gap_mode = GAP_WIDE;
  logic        shadow_cosine = 1'b1;
  logic [fbe_pkg::DEF_HARMONIC_BITS-1:0] shadow_harmonic = '0;
  int          mismatches = 0;
  int          items_taken = 0;
  int          results_seen = 0;
  int          settings_used = 0;
  int          cycles = 0;

  fourier_basis_evaluator dut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .angle             (angle),
    .done              (done),
    .value             (value),
    .first_derivative  (first_derivative),
    .second_derivative (second_derivative),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: phase to turns, wrap, quadrant fold, CORDIC, sqrt(2) and k scaling
  // ---------------------------------------------------------------------------
  function automatic longint round_q(input longint v, input int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;  // half up, floor shift
  endfunction

  function automatic basis_t predict_basis(input logic [31:0] x, input logic cos_sel,
                                           input logic [fbe_pkg::DEF_HARMONIC_BITS-1:0] k);
    basis_t res;
    logic [63:0] turns;
    logic [31:0] ph, ph_up, resid;
    fbe_pkg::quad_t quad;
    longint z, cx, sy, xs, ys, qc, qs, b, dv, b24, d24, kk;
    longint v0, v1, v2;
    int i;
    // zero harmonic: constant basis, flat derivatives
    if (k == 0) begin
      res.value  = cos_sel ? 18'sd65536 : 18'sd0;
      res.first  = '0;
      res.second = '0;
      return res;
    end
    // phase in turns, 64 fraction bits, wraps mod one turn
    turns = {{32{x[31]}}, x} * TURNS_PER_RAD;
    turns = turns * {{(64-fbe_pkg::DEF_HARMONIC_BITS){1'b0}}, k};
    ph    = turns[63:32];
    ph_up = ph + 32'h2000_0000;
    quad  = fbe_pkg::quad_t'(ph_up[31:30]);
    resid = ph - {quad, 30'd0};
    z  = longint'($signed(resid));
    cx = START_X;
    sy = 0;
    for (i = 0; i < CORDIC_STEPS; i++) begin
      xs = cx >>> i;
      ys = sy >>> i;
      if (z >= 0) begin
        cx -= ys; sy += xs; z -= ATAN_STEP[i];
      end else begin
        cx += ys; sy -= xs; z += ATAN_STEP[i];
      end
    end
    case (quad)
      fbe_pkg::QUAD_0: begin qc = cx;  qs = sy;  end
      fbe_pkg::QUAD_1: begin qc = -sy; qs = cx;  end
      fbe_pkg::QUAD_2: begin qc = -cx; qs = -sy; end
      default: begin qc = sy; qs = -cx; end
    endcase
    if (cos_sel) begin
      b = qc; dv = -qs;
    end else begin
      b = qs; dv = qc;
    end
    kk  = longint'(k);
    b24 = round_q(b * ROOT2_Q30, 36);
    d24 = round_q(dv * ROOT2_Q30, 36);
    v0  = round_q(b24, 8);
    v1  = round_q(kk * d24, 8);
    v2  = round_q(-(kk * kk) * b24, 8);
    // field widths truncate, as the block masks
    res.value  = v0[fbe_pkg::VALUE_W-1:0];
    res.first  = v1[fbe_pkg::FIRST_W-1:0];
    res.second = v2[fbe_pkg::SECOND_W-1:0];
    return res;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH @%0d: %s", cycles, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one item per accepted start, random or no hold-off between items
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !took) begin
      // item still on the port, waiting for busy to drop
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left--;
    end else if (angles_waiting.size() != 0) begin
      start <= 1'b1;
      angle <= angles_waiting.pop_front();
      case (gap_mode)
        GAP_NONE: gap_left = 0;
        GAP_WIDE: gap_left = $urandom_range(0, 12);
        default: gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : 0;
      endcase
    end else begin
      start <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: mirrors register writes, predicts on accept, checks on done
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    took <= !rst && start && !busy;
    if (rst) begin
      shadow_cosine   <= 1'b1;
      shadow_harmonic <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fbe_pkg::REG_USE_COSINE: shadow_cosine   <= cfg_wdata[0];
          fbe_pkg::REG_HARMONIC:   shadow_harmonic <= cfg_wdata;
          default: ;  // undecoded index, no effect
        endcase
      end
      // done cannot be held off: take it now or lose it
      if (done !== 1'b0) begin
        results_seen++;
        if (basis_due.size() == 0) begin
          note_mismatch("result with nothing outstanding");
        end else begin
          want = basis_due.pop_front();
          if (value !== want.value)
            note_mismatch($sformatf("value got %0d want %0d", value, want.value));
          if (first_derivative !== want.first)
            note_mismatch($sformatf("first_derivative got %0d want %0d",
                                    first_derivative, want.first));
          if (second_derivative !== want.second)
            note_mismatch($sformatf("second_derivative got %0d want %0d",
                                    second_derivative, want.second));
        end
      end
      if (start && !busy) begin
        items_taken++;
        basis_due.push_back(predict_basis(angle, shadow_cosine, shadow_harmonic));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, basis_due.size());
      $display("tb_fourier_basis_evaluator: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [fbe_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [fbe_pkg::DEF_HARMONIC_BITS-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // block is idle once every item is in and every result is back
  task automatic drain();
    while (angles_waiting.size() != 0 || start) @(posedge clk);
    while (basis_due.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int n, j, pick;
    logic [31:0] a;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- directed ---
    // reset setting: cosine, k = 0 -> constant one
    angles_waiting.push_back(32'd0);
    angles_waiting.push_back(ANGLE_MAX);
    angles_waiting.push_back(ANGLE_MIN);
    settings_used++;
    drain();
    // sine with k = 0 -> zero; upper data bits must be dropped
    write_reg(fbe_pkg::REG_USE_COSINE, 8'hFE);
    angles_waiting.push_back(32'h1234_5678);
    settings_used++;
    drain();
    // k = 1 cosine: every quadrant, tiny angles around zero
    write_reg(fbe_pkg::REG_HARMONIC, 8'd1);
    write_reg(fbe_pkg::REG_USE_COSINE, 8'h01);
    angles_waiting.push_back(32'd0);
    angles_waiting.push_back(QUARTER_PI);
    angles_waiting.push_back(HALF_PI);
    angles_waiting.push_back(FULL_PI);
    angles_waiting.push_back(-HALF_PI);
    angles_waiting.push_back(32'd1);
    angles_waiting.push_back(32'hFFFF_FFFF);
    settings_used++;
    drain();
    // writes to undecoded indexes leave the setting alone
    write_reg(REG_SPARE_2, 8'hFF);
    write_reg(REG_SPARE_3, 8'h00);
    angles_waiting.push_back(HALF_PI);
    drain();
    // largest harmonic, both bases, extreme angles (phase wrap)
    write_reg(fbe_pkg::REG_HARMONIC, 8'd255);
    write_reg(fbe_pkg::REG_USE_COSINE, 8'h00);
    angles_waiting.push_back(ANGLE_MAX);
    angles_waiting.push_back(ANGLE_MIN);
    angles_waiting.push_back(32'h5555_5555);
    angles_waiting.push_back(32'hAAAA_AAAA);
    angles_waiting.push_back(HALF_PI);
    settings_used++;
    drain();
    write_reg(fbe_pkg::REG_USE_COSINE, 8'h01);
    angles_waiting.push_back(ANGLE_MAX);
    angles_waiting.push_back(ANGLE_MIN);
    angles_waiting.push_back(32'd0);
    settings_used++;
    drain();

    // --- random phases, each with a fresh setting ---
    n = 0;
    while (n < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0: write_reg(fbe_pkg::REG_HARMONIC, 8'd0);
        1: write_reg(fbe_pkg::REG_HARMONIC, 8'd1);
        2: write_reg(fbe_pkg::REG_HARMONIC, 8'd255);
        default: write_reg(fbe_pkg::REG_HARMONIC, 8'($urandom_range(0, 255)));
      endcase
      write_reg(fbe_pkg::REG_USE_COSINE, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                  8'($urandom_range(0, 255)));
      settings_used++;
      gap_mode = $urandom_range(GAP_NONE, GAP_RARE);
      j = $urandom_range(40, 160);
      if (j > RANDOM_ITEMS - n) j = RANDOM_ITEMS - n;
      while (j > 0) begin
        pick = $urandom_range(0, 9);
        if (pick <= 4) begin
          a = $urandom;
        end else if (pick <= 6) begin
          a = 32'($urandom_range(0, 65535)) - 32'd32768;
        end else if (pick == 7) begin
          // near multiples of pi/4: quadrant and octant boundaries
          a = 32'($urandom_range(0, 40)) * QUARTER_PI + 32'($urandom_range(0, 6)) - 32'd3;
          if ($urandom_range(0, 1)) a = -a;
        end else if (pick == 8) begin
          a = $urandom_range(0, 1) ? ANGLE_MAX : ANGLE_MIN;
        end else begin
          a = 32'($urandom_range(0, 2)) - 32'd1;
        end
        angles_waiting.push_back(a);
        n++;
        j--;
      end
      drain();
    end

    // --- wind down ---
    repeat (LATENCY + 8) @(posedge clk);
    while (basis_due.size() != 0) begin
      basis_due.pop_front();
      note_mismatch("expected result never arrived");
    end
    $display("covered %0d angles over %0d harmonic/basis settings, %0d results checked",
             items_taken, settings_used, results_seen);
    $display("%0d mismatches found", mismatches);
    if (mismatches == 0) begin
      $display("tb_fourier_basis_evaluator: done, clean");
    end else begin
      $display("tb_fourier_basis_evaluator: done, errors");
    end
    $finish;
  end

endmodule
